@@ src/fat_chain_allocator_core_macros.svh @@
// Assertion macros used by the checker of the allocation table core.
`ifndef FAT_CHAIN_ALLOCATOR_CORE_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fca same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fca next-cycle check failed");

`endif

@@ src/fca_pkg.sv @@
// Shared types, constants and control records of the allocation table core.
package fca_pkg;

	localparam int TABLE_ENTRIES_DEF = 8192;
	localparam int CMD_W = 3;
	localparam int DATA_W = 16;
	localparam int CNT_W = 14;
	localparam int ST_W = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	localparam logic [DATA_W-1:0] END_MARK = 16'hFFFF;
	localparam logic [CNT_W-1:0] DBC_RESET = 14'd8192;

	typedef enum logic [CMD_W-1:0] {
		CMD_START  = 3'd0,
		CMD_NEXT   = 3'd1,
		CMD_FOLLOW = 3'd2,
		CMD_FREE   = 3'd3,
		CMD_COUNT  = 3'd4,
		CMD_LOAD   = 3'd5,
		CMD_READ   = 3'd6
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_LINK_END,
		S_NEXT_CHK,
		S_READ_CHK,
		S_FREE_RD,
		S_FREE_CHK,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_PTR_END,
		WR_PTR_ZERO,
		WR_IDX_PTR,
		WR_IDX_VAL
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_IDX,
		RD_PTR
	} rd_sel_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ONE,
		PTR_IDX,
		PTR_RD,
		PTR_INC
	} ptr_sel_t;

	typedef enum logic [1:0] {
		LINK_HOLD,
		LINK_RD,
		LINK_PTR
	} link_sel_t;

	typedef struct packed {
		logic      load_in;
		wr_sel_t   wr_sel;
		rd_sel_t   rd_sel;
		ptr_sel_t  ptr_sel;
		link_sel_t link_sel;
		logic      cnt_inc;
		logic      st_en;
		status_t   st_val;
		logic      out_load;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic idx_in_range;
		logic idx_is_end;
		logic ptr_below_n;
		logic rd_zero;
		logic rd_end;
		logic clr_last;
		logic out_free;
	} sts_t;

	localparam ctl_t CTL_NONE = '{
		load_in:  1'b0,
		wr_sel:   WR_NONE,
		rd_sel:   RD_NONE,
		ptr_sel:  PTR_HOLD,
		link_sel: LINK_HOLD,
		cnt_inc:  1'b0,
		st_en:    1'b0,
		st_val:   ST_OK,
		out_load: 1'b0
	};

endpackage

@@ src/fca_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module fca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

@@ src/fca_datapath.sv @@
// Datapath of the allocation table core: table memory, walk pointer, result and output registers.
module fca_datapath #(
	parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [fca_pkg::CNT_W-1:0]      cfg_wr_data,
	input  logic [fca_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fca_pkg::M_TDATA_W-1:0]  m_tdata,
	input  fca_pkg::ctl_t                  ctl,
	output fca_pkg::sts_t                  sts
);
	import fca_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [DATA_W-1:0] ENTRIES_W = DATA_W'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_ENTRIES - 1);

	logic [CNT_W-1:0]     dbc_q;
	cmd_t                 cmd_q;
	logic [DATA_W-1:0]    idx_q;
	logic [DATA_W-1:0]    val_q;
	logic [DATA_W-1:0]    ptr_q;
	logic [DATA_W-1:0]    link_q;
	logic [CNT_W-1:0]     count_q;
	status_t              status_q;
	logic [AW-1:0]        clr_q;
	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [DATA_W-1:0] n;
	logic [DATA_W-1:0] dbc_ext;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign dbc_ext = DATA_W'(dbc_q);
	assign n = (dbc_ext < ENTRIES_W) ? dbc_ext : ENTRIES_W;

	always_comb begin
		ram_we = 1'b1;
		ram_waddr = ptr_q[AW-1:0];
		ram_wdata = '0;
		case (ctl.wr_sel)
			WR_NONE: begin
				ram_we = 1'b0;
			end
			WR_CLEAR: begin
				ram_waddr = clr_q;
			end
			WR_PTR_END: begin
				ram_wdata = END_MARK;
			end
			WR_PTR_ZERO: begin
				ram_wdata = '0;
			end
			WR_IDX_PTR: begin
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = ptr_q;
			end
			WR_IDX_VAL: begin
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = val_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re = (ctl.rd_sel != RD_NONE);
	assign ram_raddr = (ctl.rd_sel == RD_IDX) ? idx_q[AW-1:0] : ptr_q[AW-1:0];

	fca_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en(ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbc_q <= DBC_RESET;
			clr_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dbc_q <= cfg_wr_data;
			end
			if (ctl.wr_sel == WR_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctl.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= cmd_t'(s_tdata[CMD_W-1:0]);
			idx_q <= s_tdata[CMD_W +: DATA_W];
			val_q <= s_tdata[CMD_W+DATA_W +: DATA_W];
			link_q <= '0;
			count_q <= '0;
			status_q <= ST_OK;
		end else begin
			case (ctl.link_sel)
				LINK_RD:   link_q <= ram_rdata;
				LINK_PTR:  link_q <= ptr_q;
				default:   link_q <= link_q;
			endcase
			if (ctl.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctl.st_en) begin
				status_q <= ctl.st_val;
			end
		end
		case (ctl.ptr_sel)
			PTR_ONE: ptr_q <= DATA_W'(1);
			PTR_IDX: ptr_q <= idx_q;
			PTR_RD:  ptr_q <= ram_rdata;
			PTR_INC: ptr_q <= ptr_q + DATA_W'(1);
			default: ptr_q <= ptr_q;
		endcase
		if (ctl.out_load) begin
			m_tdata_q <= {count_q, link_q, status_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_tdata_q;

	assign sts.cmd = cmd_q;
	assign sts.idx_in_range = (idx_q < n);
	assign sts.idx_is_end = (idx_q == END_MARK);
	assign sts.ptr_below_n = (ptr_q < n);
	assign sts.rd_zero = (ram_rdata == '0);
	assign sts.rd_end = (ram_rdata == END_MARK);
	assign sts.clr_last = (clr_q == LAST_ENTRY);
	assign sts.out_free = !m_valid_q || m_tready;
endmodule

@@ src/fca_ctrl.sv @@
// Controller state machine that sequences each command over the table datapath.
module fca_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  fca_pkg::sts_t sts,
	output fca_pkg::ctl_t ctl
);
	import fca_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = CTL_NONE;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ctl.wr_sel = WR_CLEAR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load_in = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (sts.cmd)
					CMD_START, CMD_COUNT: begin
						ctl.ptr_sel = PTR_ONE;
						state_d = S_SCAN_RD;
					end
					CMD_NEXT: begin
						if (!sts.idx_in_range) begin
							ctl.st_en = 1'b1;
							ctl.st_val = ST_RANGE;
						end else begin
							ctl.rd_sel = RD_IDX;
							state_d = S_NEXT_CHK;
						end
					end
					CMD_FOLLOW, CMD_READ: begin
						if (!sts.idx_in_range) begin
							ctl.st_en = 1'b1;
							ctl.st_val = ST_RANGE;
						end else begin
							ctl.rd_sel = RD_IDX;
							state_d = S_READ_CHK;
						end
					end
					CMD_FREE: begin
						if (sts.idx_is_end) begin
							state_d = S_DONE;
						end else if (!sts.idx_in_range) begin
							ctl.st_en = 1'b1;
							ctl.st_val = ST_RANGE;
						end else begin
							ctl.ptr_sel = PTR_IDX;
							state_d = S_FREE_RD;
						end
					end
					CMD_LOAD: begin
						if (!sts.idx_in_range) begin
							ctl.st_en = 1'b1;
							ctl.st_val = ST_RANGE;
						end else begin
							ctl.wr_sel = WR_IDX_VAL;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (!sts.ptr_below_n) begin
					if (sts.cmd != CMD_COUNT) begin
						ctl.st_en = 1'b1;
						ctl.st_val = ST_FULL;
					end
					state_d = S_DONE;
				end else begin
					ctl.rd_sel = RD_PTR;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (sts.cmd == CMD_COUNT) begin
					ctl.cnt_inc = sts.rd_zero;
					ctl.ptr_sel = PTR_INC;
					state_d = S_SCAN_RD;
				end else if (!sts.rd_zero) begin
					ctl.ptr_sel = PTR_INC;
					state_d = S_SCAN_RD;
				end else if (sts.cmd == CMD_NEXT) begin
					ctl.wr_sel = WR_IDX_PTR;
					state_d = S_LINK_END;
				end else begin
					ctl.wr_sel = WR_PTR_END;
					ctl.link_sel = LINK_PTR;
					state_d = S_DONE;
				end
			end
			S_LINK_END: begin
				ctl.wr_sel = WR_PTR_END;
				ctl.link_sel = LINK_PTR;
				state_d = S_DONE;
			end
			S_NEXT_CHK: begin
				if (sts.rd_end) begin
					ctl.ptr_sel = PTR_ONE;
					state_d = S_SCAN_RD;
				end else begin
					ctl.link_sel = LINK_RD;
					state_d = S_DONE;
				end
			end
			S_READ_CHK: begin
				ctl.link_sel = LINK_RD;
				state_d = S_DONE;
			end
			S_FREE_RD: begin
				if (!sts.ptr_below_n) begin
					ctl.st_en = 1'b1;
					ctl.st_val = ST_RANGE;
					state_d = S_DONE;
				end else begin
					ctl.rd_sel = RD_PTR;
					state_d = S_FREE_CHK;
				end
			end
			S_FREE_CHK: begin
				if (sts.rd_zero) begin
					state_d = S_DONE;
				end else begin
					ctl.wr_sel = WR_PTR_ZERO;
					ctl.cnt_inc = 1'b1;
					if (sts.rd_end) begin
						state_d = S_DONE;
					end else begin
						ctl.ptr_sel = PTR_RD;
						state_d = S_FREE_RD;
					end
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

@@ src/fat_chain_allocator_core.sv @@
// Top level of the cluster chain allocation table core.
// After reset the core zeroes its table, one entry per cycle, before it takes the
// first command beat; configuration writes are taken throughout. Commands run one
// at a time from a table memory with one registered read port, so each table read
// is issued in one state and its data checked in the next. Load, free from the end
// marker, the unused command and every index range error read no table entry;
// follow, read and next or extend on an entry that does not end its chain read that
// entry once. Start chain scans upward from entry 1 to the lowest free entry, and
// next or extend that extends does the same and then links the new entry; when no
// entry is free the scan stops at n, the active entry count. Free chain walks its
// links, zeroing each, until the end marker, a free entry or an entry out of range;
// count free scans the active entries from entry 1. The result beat is shown in the
// same cycle in which the next command beat can be taken. A new command beat is
// taken while the previous result beat waits; a finished command that finds the
// output register still full waits until that beat is taken.
module fat_chain_allocator_core #(
	parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fca_pkg::CNT_W-1:0]     cfg_wr_data,   // data_block_count
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fca_pkg::S_TDATA_W-1:0] s_tdata,       // command, entry_index, entry_value
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fca_pkg::M_TDATA_W-1:0] m_tdata        // status, link_value, entry_count
);
	import fca_pkg::*;

	ctl_t ctl;
	sts_t sts;

	fca_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.ctl(ctl)
	);

	fca_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.ctl(ctl),
		.sts(sts)
	);
endmodule

@@ src/fca_checker.sv @@
// Port-level checker for the allocation table core and its bind to the top level.
`include "fat_chain_allocator_core_macros.svh"

module fca_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fca_pkg::M_TDATA_W-1:0] m_tdata
);
	`FCA_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`FCA_ASSERT_NEXT(a_out_data_holds, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`FCA_ASSERT_NEXT(a_one_cmd_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`FCA_ASSERT_SAME(a_status_code, clk, arst_n, m_tvalid, m_tdata[1:0] != 2'b11)
	`FCA_ASSERT_SAME(a_error_link_zero, clk, arst_n, m_tvalid && (m_tdata[1:0] != fca_pkg::ST_OK),
		m_tdata[17:2] == 16'h0000)
endmodule

bind fat_chain_allocator_core fca_checker u_fca_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
